/* rtl/core/tpe_pkg.sv */
// shared types, constants and tables of the trivariate polynomial evaluator
package tpe_pkg;

  // default polynomial order and fixed field widths
  localparam int ORDER_DEF = 3;
  localparam int EXP_W     = 3;   // holds exponents up to the largest supported order
  localparam int IDX_W     = 7;   // holds term numbers up to the largest supported order
  localparam int R_W       = 4;   // result slot number
  localparam int NRES      = 10;  // value, gradient, six hessian entries
  localparam int D_W       = 48;  // Q32.16 datapath word
  localparam int PT_W      = 24;  // Q8.16 coordinate
  localparam int CF_W      = 32;  // Q16.16 coefficient

  localparam logic signed [D_W-1:0] ONE_Q16 = 48'sd65536;
  localparam logic signed [D_W-1:0] RES_MAX = {1'b0, {(D_W-1){1'b1}}};
  localparam logic signed [D_W-1:0] RES_MIN = {1'b1, {(D_W-1){1'b0}}};

  // coordinate numbers
  localparam logic [1:0] V_X = 2'd0;
  localparam logic [1:0] V_Z = 2'd2;

  // derivative order per result slot and coordinate
  localparam logic [1:0] DERIV_ORD [NRES][3] = '{
    '{2'd0, 2'd0, 2'd0}, '{2'd1, 2'd0, 2'd0}, '{2'd0, 2'd1, 2'd0}, '{2'd0, 2'd0, 2'd1},
    '{2'd2, 2'd0, 2'd0}, '{2'd1, 2'd1, 2'd0}, '{2'd1, 2'd0, 2'd1}, '{2'd0, 2'd2, 2'd0},
    '{2'd0, 2'd1, 2'd1}, '{2'd0, 2'd0, 2'd2}
  };

  // controller states
  typedef enum logic [3:0] {
    S_IDLE, S_POW_GO, S_POW_WAIT, S_FACT, S_M1_GO, S_M1_WAIT,
    S_M2_GO, S_M2_WAIT, S_M3_GO, S_M3_WAIT, S_ACC, S_DONE
  } state_t;

  // multiplier operand selection
  typedef enum logic [1:0] {MS_POW, MS_COEF, MS_Y, MS_Z} mul_src_t;

  // command word from controller to datapath
  typedef struct packed {
    logic             write_en;
    logic             load_pt;
    logic             mul_start;
    mul_src_t         mul_src;
    logic             fact_en;
    logic             acc_en;
    logic [1:0]       v;
    logic [EXP_W-1:0] k;
    logic [EXP_W-1:0] a;
    logic [EXP_W-1:0] b;
    logic [EXP_W-1:0] c;
    logic [IDX_W-1:0] n;
    logic [R_W-1:0]   r;
  } dp_cmd_t;

endpackage

/* rtl/core/trivariate_polynomial_evaluator.sv */
// top level of the trivariate polynomial evaluator with gradient and hessian
//
//   channel  handshake          fields
//   input    start / busy       in_op, in_coef_index, in_coef_value, in_px, in_py, in_pz
//   result   out_strobe         out_value, out_grad_*, out_hess_*, out_overflow
//
// a coefficient write is taken while idle and busy stays low.
// an evaluate beat takes 3*ORDER power products, then per term and result slot one
// factor step, three products and one accumulate step, each product on the single
// shared multiplier, which finishes early when an operand is zero.
// the result shows for one cycle with out_strobe; the receiver cannot stall it.
// reset is synchronous, active low; coefficients read as zero until written.
module trivariate_polynomial_evaluator #(
  parameter int ORDER = tpe_pkg::ORDER_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_op,
  input  logic [4:0]                        in_coef_index,
  input  logic signed [tpe_pkg::CF_W-1:0]   in_coef_value,
  input  logic signed [tpe_pkg::PT_W-1:0]   in_px,
  input  logic signed [tpe_pkg::PT_W-1:0]   in_py,
  input  logic signed [tpe_pkg::PT_W-1:0]   in_pz,
  output logic                              out_strobe,
  output logic signed [tpe_pkg::D_W-1:0]    out_value,
  output logic signed [tpe_pkg::D_W-1:0]    out_grad_x,
  output logic signed [tpe_pkg::D_W-1:0]    out_grad_y,
  output logic signed [tpe_pkg::D_W-1:0]    out_grad_z,
  output logic signed [tpe_pkg::D_W-1:0]    out_hess_xx,
  output logic signed [tpe_pkg::D_W-1:0]    out_hess_xy,
  output logic signed [tpe_pkg::D_W-1:0]    out_hess_xz,
  output logic signed [tpe_pkg::D_W-1:0]    out_hess_yy,
  output logic signed [tpe_pkg::D_W-1:0]    out_hess_yz,
  output logic signed [tpe_pkg::D_W-1:0]    out_hess_zz,
  output logic                              out_overflow
);

  tpe_pkg::dp_cmd_t cmd;
  logic             mul_done;
  logic [tpe_pkg::NRES-1:0][tpe_pkg::D_W-1:0] acc;

  // sequencer
  tpe_ctrl #(.ORDER(ORDER)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_op      (in_op),
    .mul_done   (mul_done),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  // arithmetic
  tpe_datapath #(.ORDER(ORDER)) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .in_coef_index (in_coef_index),
    .in_coef_value (in_coef_value),
    .in_px         (in_px),
    .in_py         (in_py),
    .in_pz         (in_pz),
    .mul_done      (mul_done),
    .acc_o         (acc),
    .sat_o         (out_overflow)
  );

  // result beat fields
  assign out_value   = acc[0];
  assign out_grad_x  = acc[1];
  assign out_grad_y  = acc[2];
  assign out_grad_z  = acc[3];
  assign out_hess_xx = acc[4];
  assign out_hess_xy = acc[5];
  assign out_hess_xz = acc[6];
  assign out_hess_yy = acc[7];
  assign out_hess_yz = acc[8];
  assign out_hess_zz = acc[9];

endmodule

/* rtl/core/tpe_mul.sv */
// multi-cycle saturating Q.16 multiplier built from 24x24 partial products
module tpe_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [tpe_pkg::D_W-1:0] a_in,
  input  logic signed [tpe_pkg::D_W-1:0] b_in,
  output logic                           done,
  output logic signed [tpe_pkg::D_W-1:0] res,
  output logic                           ovf
);

  localparam int H_W = tpe_pkg::D_W / 2;
  localparam int S_W = 2 * tpe_pkg::D_W;

  logic [tpe_pkg::D_W-1:0] a_mag, b_mag, a_mag_r, b_mag_r;
  logic                    neg_r;
  logic [S_W-1:0]          sum_r;
  logic [1:0]              cnt_r;
  logic                    act_r, fin_r, done_r;
  logic signed [tpe_pkg::D_W-1:0] res_r, res_c;
  logic                    ovf_r, ovf_c;
  logic [H_W-1:0]          op_a, op_b;
  logic [tpe_pkg::D_W-1:0] pp;
  logic [S_W-1:0]          pp_sh;
  logic [tpe_pkg::D_W-2:0] mag_q;

  // operand magnitudes
  assign a_mag = a_in[tpe_pkg::D_W-1] ? tpe_pkg::D_W'(-a_in) : tpe_pkg::D_W'(a_in);
  assign b_mag = b_in[tpe_pkg::D_W-1] ? tpe_pkg::D_W'(-b_in) : tpe_pkg::D_W'(b_in);

  // one partial product per cycle: lo*lo, lo*hi, hi*lo, hi*hi
  assign op_a = cnt_r[1] ? a_mag_r[tpe_pkg::D_W-1:H_W] : a_mag_r[H_W-1:0];
  assign op_b = cnt_r[0] ? b_mag_r[tpe_pkg::D_W-1:H_W] : b_mag_r[H_W-1:0];
  assign pp   = op_a * op_b;

  always_comb begin
    unique case (cnt_r)
      2'd0:    pp_sh = S_W'(pp);
      2'd3:    pp_sh = S_W'(pp) << tpe_pkg::D_W;
      default: pp_sh = S_W'(pp) << H_W;
    endcase
  end

  // truncate toward zero, saturate on a product of 2^63 or more
  assign ovf_c = |sum_r[S_W-1:63];
  assign mag_q = sum_r[62:16];
  always_comb begin
    if (ovf_c) begin
      res_c = neg_r ? tpe_pkg::RES_MIN : tpe_pkg::RES_MAX;
    end else if (neg_r) begin
      res_c = -$signed({1'b0, mag_q});
    end else begin
      res_c = $signed({1'b0, mag_q});
    end
  end

  // sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      done_r <= fin_r;
      if (start) begin
        act_r <= (a_mag != '0) && (b_mag != '0);
        fin_r <= (a_mag == '0) || (b_mag == '0);
        cnt_r <= 2'd0;
      end else if (act_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          act_r <= 1'b0;
          fin_r <= 1'b1;
        end
      end else begin
        fin_r <= 1'b0;
      end
    end
  end

  // operands, running sum and result
  always_ff @(posedge clk) begin
    if (start) begin
      a_mag_r <= a_mag;
      b_mag_r <= b_mag;
      neg_r   <= a_in[tpe_pkg::D_W-1] ^ b_in[tpe_pkg::D_W-1];
      sum_r   <= '0;
    end else if (act_r) begin
      sum_r <= sum_r + pp_sh;
    end
    if (fin_r) begin
      res_r <= res_c;
      ovf_r <= ovf_c;
    end
  end

  assign done = done_r;
  assign res  = res_r;
  assign ovf  = ovf_r;

endmodule

/* rtl/core/tpe_datapath.sv */
// coefficient store, powers, derivative factors, multiplier and accumulators
module tpe_datapath #(
  parameter int ORDER = tpe_pkg::ORDER_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tpe_pkg::dp_cmd_t                     cmd,
  input  logic [4:0]                           in_coef_index,
  input  logic signed [tpe_pkg::CF_W-1:0]      in_coef_value,
  input  logic signed [tpe_pkg::PT_W-1:0]      in_px,
  input  logic signed [tpe_pkg::PT_W-1:0]      in_py,
  input  logic signed [tpe_pkg::PT_W-1:0]      in_pz,
  output logic                                 mul_done,
  output logic [tpe_pkg::NRES-1:0][tpe_pkg::D_W-1:0] acc_o,
  output logic                                 sat_o
);

  localparam int NTERMS = ((ORDER + 1) * (ORDER + 2) * (ORDER + 3)) / 6;
  localparam int A_W    = (NTERMS > 1) ? $clog2(NTERMS) : 1;
  localparam int E_W    = (ORDER > 0) ? $clog2(ORDER + 1) : 1;
  localparam int K_W    = $clog2(ORDER * ORDER + 2);
  localparam int P_W    = tpe_pkg::D_W + K_W;

  // coefficient memory with per-entry valid bits
  logic [tpe_pkg::CF_W-1:0]        coef_mem [NTERMS];
  logic [NTERMS-1:0]               valid_r;
  logic signed [tpe_pkg::CF_W-1:0] coef_rd_r;
  logic [A_W-1:0]                  wr_addr, rd_addr;

  logic signed [tpe_pkg::D_W-1:0] pt_r  [3];
  logic signed [tpe_pkg::D_W-1:0] pw_r  [3][ORDER+1];
  logic signed [tpe_pkg::D_W-1:0] fac_r [3];
  logic signed [tpe_pkg::D_W-1:0] t_r;
  logic signed [tpe_pkg::D_W-1:0] acc_r [tpe_pkg::NRES];
  logic                           sat_r;

  logic signed [tpe_pkg::D_W-1:0] mul_a, mul_b, mul_res;
  logic                           mul_ovf;

  logic [tpe_pkg::EXP_W-1:0]      e_c   [3];
  logic [1:0]                     d_c   [3];
  logic [K_W-1:0]                 k_c   [3];
  logic signed [tpe_pkg::D_W-1:0] src_c [3];
  logic [tpe_pkg::D_W-1:0]        mag_c [3];
  logic [P_W-1:0]                 prod_c[3];
  logic                           fsat_c[3];
  logic signed [tpe_pkg::D_W-1:0] fval_c[3];

  logic signed [tpe_pkg::D_W:0]   acc_sum;
  logic signed [tpe_pkg::D_W-1:0] acc_new;
  logic                           acc_sat;

  assign wr_addr = A_W'(in_coef_index);
  assign rd_addr = A_W'(cmd.n);

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.write_en && (32'(in_coef_index) < NTERMS)) begin
      coef_mem[wr_addr] <= in_coef_value;
    end
    coef_rd_r <= valid_r[rd_addr] ? $signed(coef_mem[rd_addr]) : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.write_en && (32'(in_coef_index) < NTERMS)) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // multiplier operand select
  always_comb begin
    unique case (cmd.mul_src)
      tpe_pkg::MS_POW: begin
        mul_a = pw_r[cmd.v][E_W'(cmd.k - tpe_pkg::EXP_W'(1))];
        mul_b = pt_r[cmd.v];
      end
      tpe_pkg::MS_COEF: begin
        mul_a = tpe_pkg::D_W'(coef_rd_r);
        mul_b = fac_r[0];
      end
      tpe_pkg::MS_Y: begin
        mul_a = t_r;
        mul_b = fac_r[1];
      end
      default: begin
        mul_a = t_r;
        mul_b = fac_r[2];
      end
    endcase
  end

  tpe_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a_in  (mul_a),
    .b_in  (mul_b),
    .done  (mul_done),
    .res   (mul_res),
    .ovf   (mul_ovf)
  );

  // derivative factor per coordinate: p^(e-d) times e, e(e-1) or one
  assign e_c[0] = cmd.a;
  assign e_c[1] = cmd.b;
  assign e_c[2] = cmd.c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_c[i] = tpe_pkg::DERIV_ORD[cmd.r][i];
      unique case (d_c[i])
        2'd0:    k_c[i] = K_W'(1);
        2'd1:    k_c[i] = K_W'(e_c[i]);
        2'd2:    k_c[i] = K_W'(K_W'(e_c[i]) * (K_W'(e_c[i]) - K_W'(1)));
        default: k_c[i] = '0;
      endcase
      src_c[i]  = pw_r[i][E_W'(e_c[i] - tpe_pkg::EXP_W'(d_c[i]))];
      mag_c[i]  = src_c[i][tpe_pkg::D_W-1] ? tpe_pkg::D_W'(-src_c[i])
                                           : tpe_pkg::D_W'(src_c[i]);
      prod_c[i] = P_W'(mag_c[i]) * P_W'(k_c[i]);
      if (e_c[i] < tpe_pkg::EXP_W'(d_c[i])) begin
        fsat_c[i] = 1'b0;
        fval_c[i] = '0;
      end else if (|prod_c[i][P_W-1:tpe_pkg::D_W-1]) begin
        fsat_c[i] = 1'b1;
        fval_c[i] = src_c[i][tpe_pkg::D_W-1] ? tpe_pkg::RES_MIN : tpe_pkg::RES_MAX;
      end else begin
        fsat_c[i] = 1'b0;
        fval_c[i] = src_c[i][tpe_pkg::D_W-1]
                  ? -$signed({1'b0, prod_c[i][tpe_pkg::D_W-2:0]})
                  :  $signed({1'b0, prod_c[i][tpe_pkg::D_W-2:0]});
      end
    end
  end

  // saturating accumulate
  assign acc_sum = {acc_r[cmd.r][tpe_pkg::D_W-1], acc_r[cmd.r]} + {t_r[tpe_pkg::D_W-1], t_r};
  always_comb begin
    acc_sat = acc_sum[tpe_pkg::D_W] != acc_sum[tpe_pkg::D_W-1];
    if (!acc_sat) begin
      acc_new = acc_sum[tpe_pkg::D_W-1:0];
    end else if (acc_sum[tpe_pkg::D_W]) begin
      acc_new = tpe_pkg::RES_MIN;
    end else begin
      acc_new = tpe_pkg::RES_MAX;
    end
  end

  // overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r <= 1'b0;
    end else if (cmd.load_pt) begin
      sat_r <= 1'b0;
    end else begin
      if (cmd.fact_en && (fsat_c[0] || fsat_c[1] || fsat_c[2])) sat_r <= 1'b1;
      if (mul_done && mul_ovf) sat_r <= 1'b1;
      if (cmd.acc_en && acc_sat) sat_r <= 1'b1;
    end
  end

  // point, powers, factors, product and accumulators
  always_ff @(posedge clk) begin
    if (cmd.load_pt) begin
      pt_r[0] <= tpe_pkg::D_W'(in_px);
      pt_r[1] <= tpe_pkg::D_W'(in_py);
      pt_r[2] <= tpe_pkg::D_W'(in_pz);
      for (int i = 0; i < 3; i++) begin
        pw_r[i][0] <= tpe_pkg::ONE_Q16;
      end
      for (int j = 0; j < tpe_pkg::NRES; j++) begin
        acc_r[j] <= '0;
      end
    end
    if (cmd.fact_en) begin
      for (int i = 0; i < 3; i++) begin
        fac_r[i] <= fval_c[i];
      end
    end
    if (mul_done) begin
      if (cmd.mul_src == tpe_pkg::MS_POW) begin
        pw_r[cmd.v][E_W'(cmd.k)] <= mul_res;
      end else begin
        t_r <= mul_res;
      end
    end
    if (cmd.acc_en) begin
      acc_r[cmd.r] <= acc_new;
    end
  end

  always_comb begin
    for (int j = 0; j < tpe_pkg::NRES; j++) begin
      acc_o[j] = acc_r[j];
    end
  end
  assign sat_o = sat_r;

endmodule

/* rtl/core/tpe_ctrl.sv */
// sequencer: powers, then per term and result slot factor, three products, accumulate
module tpe_ctrl #(
  parameter int ORDER = tpe_pkg::ORDER_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_op,
  input  logic             mul_done,
  output tpe_pkg::dp_cmd_t cmd,
  output logic             busy,
  output logic             out_strobe
);

  localparam logic [tpe_pkg::EXP_W-1:0] ORD = tpe_pkg::EXP_W'(ORDER);
  localparam logic [tpe_pkg::R_W-1:0]   LAST_R = tpe_pkg::R_W'(tpe_pkg::NRES - 1);

  tpe_pkg::state_t state_r, state_nxt;
  logic [1:0]                v_r, v_nxt;
  logic [tpe_pkg::EXP_W-1:0] k_r, k_nxt, a_r, a_nxt, b_r, b_nxt, c_r, c_nxt;
  logic [tpe_pkg::IDX_W-1:0] n_r, n_nxt;
  logic [tpe_pkg::R_W-1:0]   r_r, r_nxt;
  logic                      last_term;

  assign last_term = (a_r == '0) && (b_r == '0) && (c_r == '0);

  // next state and loop indices
  always_comb begin
    state_nxt = state_r;
    v_nxt = v_r;
    k_nxt = k_r;
    a_nxt = a_r;
    b_nxt = b_r;
    c_nxt = c_r;
    n_nxt = n_r;
    r_nxt = r_r;
    unique case (state_r)
      tpe_pkg::S_IDLE: begin
        if (start && in_op) begin
          v_nxt = tpe_pkg::V_X;
          k_nxt = tpe_pkg::EXP_W'(1);
          a_nxt = ORD;
          b_nxt = '0;
          c_nxt = '0;
          n_nxt = '0;
          r_nxt = '0;
          state_nxt = (ORDER > 0) ? tpe_pkg::S_POW_GO : tpe_pkg::S_FACT;
        end
      end
      tpe_pkg::S_POW_GO:  state_nxt = tpe_pkg::S_POW_WAIT;
      tpe_pkg::S_POW_WAIT: begin
        if (mul_done) begin
          if (k_r == ORD) begin
            k_nxt = tpe_pkg::EXP_W'(1);
            if (v_r == tpe_pkg::V_Z) begin
              state_nxt = tpe_pkg::S_FACT;
            end else begin
              v_nxt = v_r + 2'd1;
              state_nxt = tpe_pkg::S_POW_GO;
            end
          end else begin
            k_nxt = k_r + tpe_pkg::EXP_W'(1);
            state_nxt = tpe_pkg::S_POW_GO;
          end
        end
      end
      tpe_pkg::S_FACT:    state_nxt = tpe_pkg::S_M1_GO;
      tpe_pkg::S_M1_GO:   state_nxt = tpe_pkg::S_M1_WAIT;
      tpe_pkg::S_M1_WAIT: if (mul_done) state_nxt = tpe_pkg::S_M2_GO;
      tpe_pkg::S_M2_GO:   state_nxt = tpe_pkg::S_M2_WAIT;
      tpe_pkg::S_M2_WAIT: if (mul_done) state_nxt = tpe_pkg::S_M3_GO;
      tpe_pkg::S_M3_GO:   state_nxt = tpe_pkg::S_M3_WAIT;
      tpe_pkg::S_M3_WAIT: if (mul_done) state_nxt = tpe_pkg::S_ACC;
      tpe_pkg::S_ACC: begin
        if (r_r == LAST_R) begin
          r_nxt = '0;
          if (last_term) begin
            state_nxt = tpe_pkg::S_DONE;
          end else begin
            // step to the next exponent triple in builder order
            n_nxt = n_r + tpe_pkg::IDX_W'(1);
            if (c_r != '0) begin
              c_nxt = c_r - tpe_pkg::EXP_W'(1);
            end else if (b_r != '0) begin
              b_nxt = b_r - tpe_pkg::EXP_W'(1);
              c_nxt = ORD - a_r - b_r + tpe_pkg::EXP_W'(1);
            end else begin
              a_nxt = a_r - tpe_pkg::EXP_W'(1);
              b_nxt = ORD - a_r + tpe_pkg::EXP_W'(1);
              c_nxt = '0;
            end
            state_nxt = tpe_pkg::S_FACT;
          end
        end else begin
          r_nxt = r_r + tpe_pkg::R_W'(1);
          state_nxt = tpe_pkg::S_FACT;
        end
      end
      tpe_pkg::S_DONE:    state_nxt = tpe_pkg::S_IDLE;
      default:            state_nxt = tpe_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tpe_pkg::S_IDLE;
      v_r <= '0;
      k_r <= '0;
      a_r <= '0;
      b_r <= '0;
      c_r <= '0;
      n_r <= '0;
      r_r <= '0;
    end else begin
      state_r <= state_nxt;
      v_r <= v_nxt;
      k_r <= k_nxt;
      a_r <= a_nxt;
      b_r <= b_nxt;
      c_r <= c_nxt;
      n_r <= n_nxt;
      r_r <= r_nxt;
    end
  end

  // commands and status
  always_comb begin
    cmd = '0;
    cmd.v = v_r;
    cmd.k = k_r;
    cmd.a = a_r;
    cmd.b = b_r;
    cmd.c = c_r;
    cmd.n = n_r;
    cmd.r = r_r;
    cmd.mul_src = tpe_pkg::MS_POW;
    busy = 1'b1;
    out_strobe = 1'b0;
    unique case (state_r)
      tpe_pkg::S_IDLE: begin
        busy = 1'b0;
        cmd.write_en = start && !in_op;
        cmd.load_pt  = start && in_op;
      end
      tpe_pkg::S_POW_GO:   cmd.mul_start = 1'b1;
      tpe_pkg::S_POW_WAIT: cmd.mul_src = tpe_pkg::MS_POW;
      tpe_pkg::S_FACT:     cmd.fact_en = 1'b1;
      tpe_pkg::S_M1_GO: begin
        cmd.mul_src = tpe_pkg::MS_COEF;
        cmd.mul_start = 1'b1;
      end
      tpe_pkg::S_M1_WAIT:  cmd.mul_src = tpe_pkg::MS_COEF;
      tpe_pkg::S_M2_GO: begin
        cmd.mul_src = tpe_pkg::MS_Y;
        cmd.mul_start = 1'b1;
      end
      tpe_pkg::S_M2_WAIT:  cmd.mul_src = tpe_pkg::MS_Y;
      tpe_pkg::S_M3_GO: begin
        cmd.mul_src = tpe_pkg::MS_Z;
        cmd.mul_start = 1'b1;
      end
      tpe_pkg::S_M3_WAIT:  cmd.mul_src = tpe_pkg::MS_Z;
      tpe_pkg::S_ACC:      cmd.acc_en = 1'b1;
      tpe_pkg::S_DONE:     out_strobe = 1'b1;
      default:             busy = 1'b1;
    endcase
  end

endmodule

/* rtl/core/tpe_checker.sv */
// port-level checks of the evaluator handshake, bound to the top level
module tpe_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_op,
  input logic out_strobe
);

  // a result beat lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("result strobe longer than one cycle");

  // a result beat only appears while an evaluation is in flight
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy) else $error("result strobe while idle");

  // an accepted evaluate beat makes the block busy
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op) |=> busy) else $error("evaluate beat not taken up");

  // a coefficient write finishes at once and gives no result
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_op) |=> (!busy && !out_strobe))
    else $error("coefficient write left block busy");

endmodule

bind trivariate_polynomial_evaluator tpe_checker u_tpe_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_op      (in_op),
  .out_strobe (out_strobe)
);

/* sim/trivariate_polynomial_evaluator_checker.sv */
// checker: predicts evaluate results from observed beats and compares them
module trivariate_polynomial_evaluator_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic                            in_op,
  input  logic [4:0]                      in_coef_index,
  input  logic signed [tpe_pkg::CF_W-1:0] in_coef_value,
  input  logic signed [tpe_pkg::PT_W-1:0] in_px,
  input  logic signed [tpe_pkg::PT_W-1:0] in_py,
  input  logic signed [tpe_pkg::PT_W-1:0] in_pz,
  input  logic                            out_strobe,
  input  logic signed [tpe_pkg::D_W-1:0]  out_value,
  input  logic signed [tpe_pkg::D_W-1:0]  out_grad_x,
  input  logic signed [tpe_pkg::D_W-1:0]  out_grad_y,
  input  logic signed [tpe_pkg::D_W-1:0]  out_grad_z,
  input  logic signed [tpe_pkg::D_W-1:0]  out_hess_xx,
  input  logic signed [tpe_pkg::D_W-1:0]  out_hess_xy,
  input  logic signed [tpe_pkg::D_W-1:0]  out_hess_xz,
  input  logic signed [tpe_pkg::D_W-1:0]  out_hess_yy,
  input  logic signed [tpe_pkg::D_W-1:0]  out_hess_yz,
  input  logic signed [tpe_pkg::D_W-1:0]  out_hess_zz,
  input  logic                            out_overflow,
  output int                              errors,
  output int                              pending
);

  localparam int ORDER  = tpe_pkg::ORDER_DEF;
  localparam int NRES   = tpe_pkg::NRES;
  localparam int D_W    = tpe_pkg::D_W;
  localparam int NTERMS = (ORDER + 1) * (ORDER + 2) * (ORDER + 3) / 6;
  localparam longint Q_MAX = 64'sd140737488355327;
  localparam longint Q_MIN = -Q_MAX - 1;

  typedef struct {
    longint slot [NRES];
    bit     ovf;
  } eval_result_t;

  logic signed [tpe_pkg::CF_W-1:0] coef_store [NTERMS];
  eval_result_t           eval_queue [$];
  logic signed [D_W-1:0]  got [NRES];
  string slot_name [NRES] = '{"value", "grad_x", "grad_y", "grad_z", "hess_xx",
                              "hess_xy", "hess_xz", "hess_yy", "hess_yz", "hess_zz"};

  assign got = '{out_value, out_grad_x, out_grad_y, out_grad_z, out_hess_xx,
                 out_hess_xy, out_hess_xz, out_hess_yy, out_hess_yz, out_hess_zz};
  assign pending = eval_queue.size();

  // q.16 product with magnitude truncation and saturation
  function automatic longint fx_mul(longint a, longint b, inout bit ovf);
    bit neg;
    logic [63:0] ma, mb, r;
    logic [127:0] p;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = {64'd0, ma} * {64'd0, mb};
    if (p >= (128'd1 << 63)) begin
      ovf = 1'b1;
      return neg ? Q_MIN : Q_MAX;
    end
    r = p[79:16];
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint fx_add(longint a, longint b, inout bit ovf);
    longint s;
    s = a + b;
    if (s > Q_MAX) begin
      ovf = 1'b1;
      return Q_MAX;
    end
    if (s < Q_MIN) begin
      ovf = 1'b1;
      return Q_MIN;
    end
    return s;
  endfunction

  // power times derivative coefficient; zero when exponent below derivative order
  function automatic longint deriv_term(longint pw [ORDER+1], int e, int d, inout bit ovf);
    longint k;
    if (e < d) return 0;
    k = (d == 0) ? 1 : (d == 1) ? e : e * (e - 1);
    return fx_mul(pw[e-d], k * 65536, ovf);
  endfunction

  function automatic eval_result_t eval_poly(longint x, longint y, longint z);
    eval_result_t res;
    longint pw [3][ORDER+1];
    longint pt [3];
    longint t, cf;
    int n;
    bit ovf;
    ovf = 1'b0;
    pt = '{x, y, z};
    for (int v = 0; v < 3; v++) begin
      pw[v][0] = 65536;
      for (int k = 1; k <= ORDER; k++) pw[v][k] = fx_mul(pw[v][k-1], pt[v], ovf);
    end
    for (int r = 0; r < NRES; r++) res.slot[r] = 0;
    n = 0;
    for (int a = ORDER; a >= 0; a--) begin
      for (int b = ORDER - a; b >= 0; b--) begin
        for (int c = ORDER - a - b; c >= 0; c--) begin
          cf = coef_store[n];
          n++;
          for (int r = 0; r < NRES; r++) begin
            t = fx_mul(cf, deriv_term(pw[0], a, tpe_pkg::DERIV_ORD[r][0], ovf), ovf);
            t = fx_mul(t, deriv_term(pw[1], b, tpe_pkg::DERIV_ORD[r][1], ovf), ovf);
            t = fx_mul(t, deriv_term(pw[2], c, tpe_pkg::DERIV_ORD[r][2], ovf), ovf);
            res.slot[r] = fx_add(res.slot[r], t, ovf);
          end
        end
      end
    end
    res.ovf = ovf;
    return res;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  initial errors = 0;

  // compare result beats, then track accepted input beats
  always @(posedge clk) begin
    eval_result_t e;
    if (!rst_n) begin
      for (int i = 0; i < NTERMS; i++) coef_store[i] = '0;
      eval_queue.delete();
    end else begin
      if (out_strobe) begin
        if (eval_queue.size() == 0) begin
          report_mismatch("result beat with nothing expected");
        end else begin
          e = eval_queue.pop_front();
          for (int r = 0; r < NRES; r++)
            if (got[r] !== e.slot[r][D_W-1:0])
              report_mismatch($sformatf("%s got %0d exp %0d", slot_name[r], got[r],
                                        e.slot[r]));
          if (out_overflow !== e.ovf)
            report_mismatch($sformatf("overflow got %b exp %b", out_overflow, e.ovf));
        end
      end
      if (start && !busy) begin
        if (in_op) eval_queue.push_back(eval_poly(in_px, in_py, in_pz));
        else if (in_coef_index < NTERMS) coef_store[in_coef_index] = in_coef_value;
      end
    end
  end

  final begin
    if (eval_queue.size() != 0) $display("%0d results never arrived", eval_queue.size());
  end
endmodule

/* sim/trivariate_polynomial_evaluator_tb.sv */
// testbench top: stimulus, watchdog and verdict for the polynomial evaluator
module trivariate_polynomial_evaluator_tb;

  localparam int PT_W = tpe_pkg::PT_W;
  localparam int CF_W = tpe_pkg::CF_W;
  localparam int D_W  = tpe_pkg::D_W;
  localparam bit OP_WRITE  = 1'b0;
  localparam bit OP_EVAL   = 1'b1;
  localparam int IDLE_LIMIT = 60000;
  localparam logic signed [PT_W-1:0] PT_MAX = {1'b0, {(PT_W-1){1'b1}}};
  localparam logic signed [PT_W-1:0] PT_MIN = {1'b1, {(PT_W-1){1'b0}}};
  localparam logic signed [CF_W-1:0] CF_MAX = {1'b0, {(CF_W-1){1'b1}}};
  localparam logic signed [CF_W-1:0] CF_MIN = {1'b1, {(CF_W-1){1'b0}}};
  localparam logic signed [CF_W-1:0] CF_ONE = 32'sd65536;

  logic clk, rst_n, start, busy;
  logic in_op;
  logic [4:0] in_coef_index;
  logic signed [CF_W-1:0] in_coef_value;
  logic signed [PT_W-1:0] in_px, in_py, in_pz;
  logic out_strobe, out_overflow;
  logic signed [D_W-1:0] out_value, out_grad_x, out_grad_y, out_grad_z;
  logic signed [D_W-1:0] out_hess_xx, out_hess_xy, out_hess_xz;
  logic signed [D_W-1:0] out_hess_yy, out_hess_yz, out_hess_zz;
  int errors, pending, quiet_cycles;

  trivariate_polynomial_evaluator uut (.*);
  trivariate_polynomial_evaluator_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no beat on either side
  initial quiet_cycles = 0;
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // drive one beat and hold it until accepted
  task automatic send_beat(bit op, logic [4:0] idx, logic signed [CF_W-1:0] cf,
                           logic signed [PT_W-1:0] x, logic signed [PT_W-1:0] y,
                           logic signed [PT_W-1:0] z);
    in_op <= op;
    in_coef_index <= idx;
    in_coef_value <= cf;
    in_px <= x;
    in_py <= y;
    in_pz <= z;
    start <= 1'b1;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic signed [CF_W-1:0] rand_coef();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return $signed($urandom_range(0, 524288)) - 262144;
  endfunction

  function automatic logic signed [PT_W-1:0] rand_point();
    if ($urandom_range(0, 6) == 0) return PT_W'($urandom);
    return PT_W'($signed($urandom_range(0, 262144)) - 131072);
  endfunction

  initial begin
    int burst;
    start = 1'b0;
    in_op = 1'b0;
    in_coef_index = '0;
    in_coef_value = '0;
    in_px = '0;
    in_py = '0;
    in_pz = '0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, ignored indexes, zero point and saturation
    send_beat(OP_EVAL, 0, 0, PT_MAX, PT_MIN, 0);
    send_beat(OP_WRITE, 0, CF_MAX, 0, 0, 0);
    send_beat(OP_WRITE, 19, CF_MIN, PT_MAX, PT_MAX, PT_MAX);
    send_beat(OP_WRITE, 9, CF_ONE, 0, 0, 0);
    send_beat(OP_WRITE, 20, CF_MAX, 0, 0, 0);
    send_beat(OP_WRITE, 31, CF_MIN, 0, 0, 0);
    send_beat(OP_EVAL, 5'd31, CF_MAX, 0, 0, 0);
    send_beat(OP_EVAL, 0, 0, PT_MAX, PT_MAX, PT_MAX);
    send_beat(OP_EVAL, 0, 0, PT_MIN, PT_MIN, PT_MIN);
    send_beat(OP_WRITE, 0, 0, 0, 0, 0);
    send_beat(OP_WRITE, 19, CF_ONE, 0, 0, 0);
    send_beat(OP_WRITE, 3, -CF_ONE, 0, 0, 0);
    send_beat(OP_WRITE, 16, 32'sd131072, 0, 0, 0);
    send_beat(OP_EVAL, 0, 0, 24'sd65536, -24'sd65536, 24'sd32768);
    send_beat(OP_EVAL, 0, 0, PT_MAX, 0, 0);
    send_beat(OP_EVAL, 0, 0, 0, PT_MIN, 24'sd1);
    wait_drained();

    // random bursts; mostly in-range writes with evaluates between
    for (int i = 0; i < 1300; ) begin
      burst = $urandom_range(1, 30);
      for (int j = 0; j < burst; j++, i++) begin
        if (i == 650) wait_drained();
        if ($urandom_range(0, 3) == 0)
          send_beat(OP_EVAL, 5'($urandom), CF_W'($urandom), rand_point(), rand_point(),
                    rand_point());
        else
          send_beat(OP_WRITE, ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                          : 5'($urandom_range(0, 19)),
                    rand_coef(), PT_W'($urandom), PT_W'($urandom), PT_W'($urandom));
      end
      if ($urandom_range(0, 7) != 0) idle_cycles($urandom_range(1, 15));
    end

    wait_drained();
    repeat (200) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
